FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the spike correlogram RTL.
// ----------------------------------------------------------------------------
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scc assertion failed");
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scc assertion failed");
`else
`define SCC_ASSERT(lbl, clk, rst_n, prop)
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and helpers of the spike cross correlogram.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int BIN_DEPTH_DEF    = 64;
    localparam int RING_A_DEPTH_DEF = 128;
    localparam int RING_B_DEPTH_DEF = 256;

    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int WIN_W  = 24;   // bin_count * bin_width < 2^23
    localparam int T2_W   = 34;   // doubled ticks plus window
    localparam int Q_W    = 7;    // bin index from the divider
    localparam int BW_W   = 16;
    localparam int BC_W   = 7;
    localparam int SEL_W  = 6;
    localparam int IDX_W  = 11;   // holds any bin index up to 1024

    localparam logic signed [15:0] B_SPIKE_LEVEL = 16'sd128;
    localparam logic [CNT_W-1:0]   CNT_MAX       = '1;

    typedef enum logic [1:0] {
        OP_STEP    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_BIN_COUNT = 2'd1,
        CFG_BIN_WIDTH = 2'd2,
        CFG_CLEAR     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [TIME_W-1:0]  time_tick;
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic [SEL_W-1:0]   bin_select;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] bin_value;
        logic [CNT_W-1:0] spikes_a;
        logic [CNT_W-1:0] spikes_b;
    } t_out_item;

    typedef struct packed {
        t_opcode           op;
        logic              spike_a;
        logic              spike_b;
        logic [TIME_W-1:0] time_tick;
        logic [SEL_W-1:0]  bin_select;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_port;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_status;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

FILE: hw/rtl/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/scc_front.sv
// ----------------------------------------------------------------------------
// scc_front
// Accept items, detect spikes, and queue commands for the back end.
// ----------------------------------------------------------------------------
module scc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  scc_pkg::t_in_item    i_item,
    input  logic signed [15:0]   i_threshold,
    output scc_pkg::t_cmd_port   o_cmd,
    input  scc_pkg::t_back_status i_status
);
    import scc_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_new;
    logic       w_push;

    always_comb begin
        w_new.op         = t_opcode'(i_item.opcode);
        w_new.spike_a    = $signed(i_item.sample_a) > i_threshold;
        w_new.spike_b    = $signed(i_item.sample_b) > B_SPIKE_LEVEL;
        w_new.time_tick  = i_item.time_tick;
        w_new.bin_select = i_item.bin_select;
    end

    assign o_ready = (r_cnt != 2'd2) && !i_status.clearing;
    assign w_push  = i_valid && o_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_status.pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(w_push) - 2'(i_status.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_new;
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];
endmodule

FILE: hw/rtl/scc_back.sv
// ----------------------------------------------------------------------------
// scc_back
// Execute queued commands: spike rings, pairing scan, bin divider, histogram.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scc_back #(
    parameter int BIN_DEPTH    = scc_pkg::BIN_DEPTH_DEF,
    parameter int RING_A_DEPTH = scc_pkg::RING_A_DEPTH_DEF,
    parameter int RING_B_DEPTH = scc_pkg::RING_B_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scc_pkg::t_cmd_port            i_cmd,
    output scc_pkg::t_back_status         o_status,
    input  logic [scc_pkg::BC_W-1:0]      i_bin_count,
    input  logic [scc_pkg::BW_W-1:0]      i_bin_width,
    input  logic                          i_clear_on_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output scc_pkg::t_out_item            o_item
);
    import scc_pkg::*;

    localparam int HAW = $clog2(BIN_DEPTH);
    localparam int AAW = $clog2(RING_A_DEPTH);
    localparam int BAW = $clog2(RING_B_DEPTH);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_STEP  = 15'b000000000000010,
        S_RA    = 15'b000000000000100,
        S_RAW   = 15'b000000000001000,
        S_SCAN  = 15'b000000000010000,
        S_BCHK  = 15'b000000000100000,
        S_DIV   = 15'b000000001000000,
        S_HRD   = 15'b000000010000000,
        S_HWR   = 15'b000000100000000,
        S_ADV   = 15'b000001000000000,
        S_READ  = 15'b000010000000000,
        S_READW = 15'b000100000000000,
        S_RST   = 15'b001000000000000,
        S_CLR   = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    t_state             r_state, n_state;
    logic [AAW-1:0]     r_head_a, n_head_a, r_ref_a, n_ref_a;
    logic [BAW-1:0]     r_head_b, n_head_b, r_scan_b, n_scan_b, r_probe, n_probe;
    logic               r_a_seen, n_a_seen, r_b_seen, n_b_seen, r_caught, n_caught;
    logic [CNT_W-1:0]   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [HAW-1:0]     r_clr_idx, n_clr_idx;
    logic               r_from_op, n_from_op;
    logic               r_out_valid, n_out_valid;

    t_cmd               r_cmd, n_cmd;
    logic [T2_W-1:0]    r_ta2, n_ta2;
    logic [WIN_W-1:0]   r_win, n_win, r_rem, n_rem;
    logic [BW_W:0]      r_bw2, n_bw2;
    logic [Q_W-1:0]     r_quo, n_quo;
    logic [2:0]         r_k, n_k;
    logic               r_last, n_last;
    logic [CNT_W-1:0]   r_value, n_value;
    t_out_item          r_out, n_out;

    logic [TIME_W-1:0]  w_qa, w_qb;
    logic [CNT_W-1:0]   w_qh;
    logic               w_we_a, w_we_b, w_re_a, w_re_b, w_we_h, w_re_h;
    logic [HAW-1:0]     w_hwaddr, w_hraddr, w_bin_addr, w_sel_addr;
    logic [CNT_W-1:0]   w_hwdata;
    logic [IDX_W-1:0]   w_bin_ext, w_sel_ext;
    logic               w_bin_ok, w_sel_ok;
    logic [BW_W-1:0]    w_bw_eff;
    logic [T2_W-1:0]    w_now2, w_win2, w_ta2, w_tb2;
    logic [WIN_W-1:0]   w_shift;

    // ------------------------------------------------------------------ memories
    scc_ram #(.WIDTH(TIME_W), .DEPTH(RING_A_DEPTH)) u_ring_a (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(n_head_a), .i_wdata(r_cmd.time_tick),
        .i_re(w_re_a), .i_raddr(r_ref_a), .o_rdata(w_qa)
    );
    scc_ram #(.WIDTH(TIME_W), .DEPTH(RING_B_DEPTH)) u_ring_b (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(n_head_b), .i_wdata(r_cmd.time_tick),
        .i_re(w_re_b), .i_raddr(r_probe), .o_rdata(w_qb)
    );
    scc_ram #(.WIDTH(CNT_W), .DEPTH(BIN_DEPTH)) u_hist (
        .i_clk(i_clk), .i_we(w_we_h), .i_waddr(w_hwaddr), .i_wdata(w_hwdata),
        .i_re(w_re_h), .i_raddr(w_hraddr), .o_rdata(w_qh)
    );

    always_comb begin
        w_bw_eff   = (i_bin_width == '0) ? BW_W'(1) : i_bin_width;
        w_now2     = {1'b0, r_cmd.time_tick, 1'b0};
        w_win2     = T2_W'(r_win);
        w_ta2      = {1'b0, w_qa, 1'b0};
        w_tb2      = {1'b0, w_qb, 1'b0};
        w_shift    = WIN_W'(r_bw2) << r_k;
        w_bin_ext  = IDX_W'(r_quo);
        w_bin_addr = w_bin_ext[HAW-1:0];
        w_bin_ok   = (r_quo < i_bin_count) && (w_bin_ext < IDX_W'(BIN_DEPTH));
        w_sel_ext  = IDX_W'(r_cmd.bin_select);
        w_sel_addr = w_sel_ext[HAW-1:0];
        w_sel_ok   = w_sel_ext < IDX_W'(BIN_DEPTH);
        w_we_a     = (r_state == S_STEP) && r_cmd.spike_a;
        w_we_b     = (r_state == S_STEP) && r_cmd.spike_b;
        w_re_a     = (r_state == S_RA);
        w_re_b     = (r_state == S_SCAN);
        w_we_h     = (r_state == S_CLR) || (r_state == S_HWR);
        w_hwaddr   = (r_state == S_CLR) ? r_clr_idx : w_bin_addr;
        w_hwdata   = (r_state == S_CLR) ? '0 : sat_inc(w_qh);
        w_re_h     = (r_state == S_READ) || ((r_state == S_HRD) && w_bin_ok);
        w_hraddr   = (r_state == S_READ) ? w_sel_addr : w_bin_addr;
    end

    assign o_status.pop      = (r_state == S_IDLE) && i_cmd.valid;
    assign o_status.clearing = (r_state == S_CLR);

    // ------------------------------------------------------------------ control
    always_comb begin
        n_state     = r_state;
        n_head_a    = r_head_a;
        n_head_b    = r_head_b;
        n_ref_a     = r_ref_a;
        n_scan_b    = r_scan_b;
        n_probe     = r_probe;
        n_a_seen    = r_a_seen;
        n_b_seen    = r_b_seen;
        n_caught    = r_caught;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_clr_idx   = r_clr_idx;
        n_from_op   = r_from_op;
        n_out_valid = r_out_valid && !i_ready;
        n_cmd       = r_cmd;
        n_ta2       = r_ta2;
        n_win       = r_win;
        n_bw2       = r_bw2;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_k         = r_k;
        n_last      = r_last;
        n_value     = r_value;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = i_cmd.cmd;
                    n_value = '0;
                    unique case (i_cmd.cmd.op)
                        OP_STEP:    n_state = S_STEP;
                        OP_READ:    n_state = S_READ;
                        OP_RESTART: n_state = S_RST;
                        OP_NONE:    n_state = S_DONE;
                    endcase
                end
            end
            S_STEP: begin
                n_win = WIN_W'(i_bin_count) * WIN_W'(w_bw_eff);
                n_bw2 = {w_bw_eff, 1'b0};
                if (r_cmd.spike_a) begin
                    n_head_a = !r_a_seen ? '0 :
                               (r_head_a == AAW'(RING_A_DEPTH - 1)) ? '0 : r_head_a + 1'b1;
                    n_a_seen = 1'b1;
                    n_cnt_a  = sat_inc(r_cnt_a);
                    n_caught = 1'b0;
                end
                if (r_cmd.spike_b) begin
                    n_head_b = !r_b_seen ? '0 :
                               (r_head_b == BAW'(RING_B_DEPTH - 1)) ? '0 : r_head_b + 1'b1;
                    n_b_seen = 1'b1;
                    n_cnt_b  = sat_inc(r_cnt_b);
                end
                n_state = (n_caught || !n_a_seen || !n_b_seen) ? S_DONE : S_RA;
            end
            S_RA: n_state = S_RAW;
            S_RAW: begin
                n_ta2 = w_ta2;
                if (w_now2 > w_ta2 + w_win2) begin
                    n_probe = r_scan_b;
                    n_state = (w_ta2 > w_win2) ? S_SCAN : S_ADV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: n_state = S_BCHK;
            S_BCHK: begin
                priority if (w_tb2 + w_win2 < r_ta2) begin
                    // too old for this and every later reference: drop it
                    if (r_head_b == r_scan_b) begin
                        n_state = S_ADV;
                    end else begin
                        n_scan_b = (r_scan_b == BAW'(RING_B_DEPTH - 1)) ? '0 : r_scan_b + 1'b1;
                        n_probe  = (r_probe == BAW'(RING_B_DEPTH - 1)) ? '0 : r_probe + 1'b1;
                        n_state  = S_SCAN;
                    end
                end else if (w_tb2 < r_ta2 + w_win2) begin
                    n_rem   = WIN_W'(w_tb2 + w_win2 - r_ta2);
                    n_quo   = '0;
                    n_k     = 3'd6;
                    n_last  = (r_head_b == r_probe);
                    n_state = S_DIV;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_DIV: begin
                if (r_rem >= w_shift) begin
                    n_rem = r_rem - w_shift;
                    n_quo = r_quo | (Q_W'(1) << r_k);
                end
                n_k = r_k - 3'd1;
                if (r_k == 3'd0) begin
                    n_state = S_HRD;
                end
            end
            S_HRD, S_HWR: begin
                if ((r_state == S_HRD) && w_bin_ok) begin
                    n_state = S_HWR;
                end else if (r_last) begin
                    n_state = S_ADV;
                end else begin
                    n_probe = (r_probe == BAW'(RING_B_DEPTH - 1)) ? '0 : r_probe + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_ADV: begin
                if (r_ref_a == r_head_a) begin
                    n_caught = 1'b1;
                end
                n_ref_a = (r_ref_a == AAW'(RING_A_DEPTH - 1)) ? '0 : r_ref_a + 1'b1;
                n_state = S_DONE;
            end
            S_READ: n_state = S_READW;
            S_READW: begin
                n_value = w_sel_ok ? w_qh : '0;
                n_state = S_DONE;
            end
            S_RST: begin
                n_head_a = '0;
                n_head_b = '0;
                n_a_seen = 1'b0;
                n_b_seen = 1'b0;
                n_ref_a  = '0;
                n_scan_b = '0;
                n_caught = 1'b1;
                n_cnt_a  = '0;
                n_cnt_b  = '0;
                if (i_clear_on_restart) begin
                    n_clr_idx = '0;
                    n_from_op = 1'b1;
                    n_state   = S_CLR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == HAW'(BIN_DEPTH - 1)) begin
                    n_state = r_from_op ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out.bin_value = r_value;
                    n_out.spikes_a  = r_cnt_a;
                    n_out.spikes_b  = r_cnt_b;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_head_a    <= '0;
            r_head_b    <= '0;
            r_ref_a     <= '0;
            r_scan_b    <= '0;
            r_probe     <= '0;
            r_a_seen    <= 1'b0;
            r_b_seen    <= 1'b0;
            r_caught    <= 1'b1;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_clr_idx   <= '0;
            r_from_op   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head_a    <= n_head_a;
            r_head_b    <= n_head_b;
            r_ref_a     <= n_ref_a;
            r_scan_b    <= n_scan_b;
            r_probe     <= n_probe;
            r_a_seen    <= n_a_seen;
            r_b_seen    <= n_b_seen;
            r_caught    <= n_caught;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_clr_idx   <= n_clr_idx;
            r_from_op   <= n_from_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ta2   <= n_ta2;
        r_win   <= n_win;
        r_bw2   <= n_bw2;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_k     <= n_k;
        r_last  <= n_last;
        r_value <= n_value;
        r_out   <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // ------------------------------------------------------------------ checks
    `SCC_ASSERT(a_pending_needs_a, i_clk, i_rst_n, !r_caught |-> r_a_seen)
    `SCC_ASSERT(a_bin_in_range, i_clk, i_rst_n, (r_state == S_HWR) |-> (r_quo < i_bin_count))
    `SCC_ASSERT_NEXT(a_restart_counts, i_clk, i_rst_n, r_state == S_RST, (r_cnt_a == '0) && (r_cnt_b == '0))
    `SCC_ASSERT_NEXT(a_catch_up, i_clk, i_rst_n, (r_state == S_ADV) && (r_ref_a == r_head_a), r_caught)
endmodule

FILE: hw/rtl/spike_cross_correlogram_top.sv
// ----------------------------------------------------------------------------
// spike_cross_correlogram_top
// Cross-correlation histogram of two spike trains with APB configuration.
// ----------------------------------------------------------------------------
// Work per item: a restart adds a histogram clearing pass when clearing is enabled;
//   a step with no pending reference, or one still too young, skips the scan; else
//   it scans B entries and divides each pair in the window, writing in-range bins.
// The back end takes one command at a time; its serial scan and the bin divider set
//   the step time, and the histogram RAM, one bin at a time, paces the rest.
// Reset: synchronous, active low; a histogram clearing pass over all BIN_DEPTH bins
//   follows reset, during which no item is taken (config writes still are).
// ----------------------------------------------------------------------------
module spike_cross_correlogram_top #(
    parameter int BIN_DEPTH    = scc_pkg::BIN_DEPTH_DEF,
    parameter int RING_A_DEPTH = scc_pkg::RING_A_DEPTH_DEF,
    parameter int RING_B_DEPTH = scc_pkg::RING_B_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  scc_pkg::t_in_item   i_item,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scc_pkg::t_out_item  o_item,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import scc_pkg::*;

    logic signed [15:0] r_threshold;
    logic [BC_W-1:0]    r_bin_count;
    logic [BW_W-1:0]    r_bin_width;
    logic               r_clear;
    t_cfg_index         w_idx;
    logic               w_cfg_wr;
    t_cmd_port          w_cmd;
    t_back_status       w_status;

    // Configuration: a transaction writes on its access cycle.
    assign pready   = 1'b1;
    assign w_idx    = t_cfg_index'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_bin_count <= BC_W'(64);
            r_bin_width <= BW_W'(1);
            r_clear     <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                CFG_THRESHOLD: r_threshold <= $signed(pwdata[15:0]);
                CFG_BIN_COUNT: r_bin_count <= pwdata[BC_W-1:0];
                CFG_BIN_WIDTH: r_bin_width <= pwdata[BW_W-1:0];
                CFG_CLEAR:     r_clear     <= pwdata[0];
            endcase
        end
    end

    // Read back the register the address selects, zero-extended.
    always_comb begin
        unique case (w_idx)
            CFG_THRESHOLD: prdata = {16'b0, r_threshold};
            CFG_BIN_COUNT: prdata = 32'(r_bin_count);
            CFG_BIN_WIDTH: prdata = 32'(r_bin_width);
            CFG_CLEAR:     prdata = 32'(r_clear);
        endcase
    end

    // Front end: detect spikes at accept time and queue the transaction.
    scc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_item),
        .i_threshold (r_threshold),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Back end: rings, pairing scan, divider, histogram, result register.
    scc_back #(
        .BIN_DEPTH    (BIN_DEPTH),
        .RING_A_DEPTH (RING_A_DEPTH),
        .RING_B_DEPTH (RING_B_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_bin_count        (r_bin_count),
        .i_bin_width        (r_bin_width),
        .i_clear_on_restart (r_clear),
        .o_valid            (o_out_valid),
        .i_ready            (i_out_ready),
        .o_item             (o_item)
    );
endmodule
